/* hdl/assert_macros.svh */
// Assertion macros shared by the verification checkers of this project.
// Each macro expects a clock named aclk and an active-low reset named aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

// Like ASSERT_NEXT, but the consequent is checked behind an added delay.
`define ASSERT_NEXT2(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> ##1 (cons)) \
        else $error("assertion failed: two-cycle check");

`endif

/* hdl/rast_pkg.sv */
// ----------------------------------------------------------------------------
// rast_pkg: shared types and constants of the refresh skip table
// Mode and register codes, controller state, command/status groups and the
// reload value calculation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rast_pkg;

    localparam logic [1:0] MODE_PROGRAM = 2'd0;
    localparam logic [1:0] MODE_REFRESH = 2'd1;
    localparam logic [1:0] MODE_RESET   = 2'd2;

    localparam logic CFG_MIN_EXP  = 1'b0;
    localparam logic CFG_MAX_SKIP = 1'b1;

    localparam logic [4:0] MIN_EXP_RST  = 5'd5;
    localparam logic [3:0] MAX_SKIP_RST = 4'd9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } ctrl_state_t;

    typedef struct packed {
        logic capture;  // latch the incoming word
        logic read;     // read both tables at the latched row
        logic update;   // write back and load the result register
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;  // result register can take a new word this cycle
    } dp_status_t;

    // Reload value from the retention exponent: number of slots a row may skip.
    function automatic logic [3:0] reload_calc(
        input logic       present,
        input logic [4:0] p,
        input logic [4:0] min_exp,
        input logic [3:0] max_skip
    );
        logic [4:0] d;
        logic [3:0] span;
        d = p - min_exp;
        // Any distance of four or more saturates the 4-bit span.
        span = (d >= 5'd4) ? 4'hF : 4'((5'd1 << d) - 5'd1);
        if (!present || (p <= min_exp)) begin
            return 4'd0;
        end
        return (span > max_skip) ? max_skip : span;
    endfunction

endpackage

`default_nettype wire

/* hdl/retention_aware_refresh_skip_table_top.sv */
// Flow: a word is captured, both row tables are read, then the write-back loads the
// result. New words wait for the write-back: read and write-back share the single
// port of each row table, and a stalled result holds the write-back in place.
// Reset: aresetn is synchronous; it clears the controller and the result valid and
// loads min_exp = 5 and max_skip = 9. The row tables are not cleared by reset.
// ----------------------------------------------------------------------------
// retention_aware_refresh_skip_table_top: retention-aware refresh skip table
// Per-row reload and count tables that decide when each row is refreshed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module retention_aware_refresh_skip_table_top import rast_pkg::*; #(
    parameter int VAULTS = 16,
    parameter int BANKS  = 8,
    parameter int ROWS   = 256
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_index,
    input  wire logic [4:0] cfg_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_mode,
    input  wire logic [3:0] s_vault_index,
    input  wire logic [2:0] s_bank_index,
    input  wire logic [7:0] s_row_index,
    input  wire logic       s_retention_present,
    input  wire logic [4:0] s_retention_log2,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_refresh,
    output logic [3:0]      m_count_value
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    rast_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rast_datapath #(
        .VAULTS (VAULTS),
        .BANKS  (BANKS),
        .ROWS   (ROWS)
    ) u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .status              (status),
        .cfg_valid           (cfg_valid),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_mode              (s_mode),
        .s_vault_index       (s_vault_index),
        .s_bank_index        (s_bank_index),
        .s_row_index         (s_row_index),
        .s_retention_present (s_retention_present),
        .s_retention_log2    (s_retention_log2),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_refresh           (m_refresh),
        .m_count_value       (m_count_value)
    );

endmodule

`default_nettype wire

/* hdl/rast_ctrl.sv */
// ----------------------------------------------------------------------------
// rast_ctrl: sequencing controller
// Steps each accepted word through table read and write-back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rast_ctrl import rast_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.read    = 1'b0;
        cmd.update  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                cmd.read   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                // Hold here while the previous result is still waiting.
                if (status.out_free) begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/rast_datapath.sv */
// ----------------------------------------------------------------------------
// rast_datapath: tables, configuration and result register
// Holds the reload and count tables, computes the row update and keeps the
// outgoing result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rast_datapath import rast_pkg::*; #(
    parameter int VAULTS = 16,
    parameter int BANKS  = 8,
    parameter int ROWS   = 256
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire ctrl_cmd_t  cmd,
    output dp_status_t      status,
    input  wire logic       cfg_valid,
    input  wire logic       cfg_index,
    input  wire logic [4:0] cfg_data,
    input  wire logic [1:0] s_mode,
    input  wire logic [3:0] s_vault_index,
    input  wire logic [2:0] s_bank_index,
    input  wire logic [7:0] s_row_index,
    input  wire logic       s_retention_present,
    input  wire logic [4:0] s_retention_log2,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_refresh,
    output logic [3:0]      m_count_value
);

    localparam int DEPTH  = VAULTS * BANKS * ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [3:0] reload_mem [DEPTH];
    logic [3:0] count_mem  [DEPTH];

    logic [4:0]        min_exp_reg;
    logic [3:0]        max_skip_reg;
    logic [1:0]        mode_reg;
    logic              present_reg;
    logic [4:0]        log2_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              in_range_reg;
    logic [3:0]        reload_rd_reg;
    logic [3:0]        count_rd_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              refresh_reg;
    logic [3:0]        count_out_reg;

    logic              in_range;
    logic [ADDR_W-1:0] addr;
    logic [3:0]        new_reload;
    logic [3:0]        new_count;
    logic              new_refresh;
    logic              reload_we;
    logic              count_we;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_exp_reg  <= MIN_EXP_RST;
            max_skip_reg <= MAX_SKIP_RST;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_MIN_EXP) begin
                min_exp_reg <= cfg_data;
            end else begin
                max_skip_reg <= cfg_data[3:0];
            end
        end
    end

    assign in_range = (32'(s_vault_index) < VAULTS) && (32'(s_bank_index) < BANKS)
                   && (32'(s_row_index) < ROWS);
    // Row-major flattening: vault, then bank, then row.
    assign addr = ADDR_W'((32'(s_vault_index) * BANKS + 32'(s_bank_index)) * ROWS
                          + 32'(s_row_index));

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg     <= s_mode;
            present_reg  <= s_retention_present;
            log2_reg     <= s_retention_log2;
            addr_reg     <= addr;
            in_range_reg <= in_range;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            reload_rd_reg <= reload_mem[addr_reg];
            count_rd_reg  <= count_mem[addr_reg];
        end
    end

    always_comb begin
        new_reload  = reload_calc(present_reg, log2_reg, min_exp_reg, max_skip_reg);
        new_count   = 4'd0;
        new_refresh = 1'b0;
        reload_we   = 1'b0;
        count_we    = 1'b0;
        if (in_range_reg) begin
            case (mode_reg)
                MODE_PROGRAM: begin
                    reload_we = 1'b1;
                    count_we  = 1'b1;
                end
                MODE_REFRESH: begin
                    count_we = 1'b1;
                    if (count_rd_reg == 4'd0) begin
                        new_refresh = 1'b1;
                        new_count   = reload_rd_reg;
                    end else begin
                        new_count = count_rd_reg - 4'd1;
                    end
                end
                MODE_RESET: begin
                    count_we  = 1'b1;
                    new_count = reload_rd_reg;
                end
                default: begin
                    count_we = 1'b0;
                end
            endcase
        end
    end

    // Program mode writes the reload into both tables but reports a zero count.
    always_ff @(posedge aclk) begin
        if (cmd.update && reload_we) begin
            reload_mem[addr_reg] <= new_reload;
        end
        if (cmd.update && count_we) begin
            count_mem[addr_reg] <= reload_we ? new_reload : new_count;
        end
    end

    assign status.out_free = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.update) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            refresh_reg   <= new_refresh;
            count_out_reg <= new_count;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_refresh     = refresh_reg;
    assign m_count_value = count_out_reg;

endmodule

`default_nettype wire

/* hdl/rast_checker.sv */
// ----------------------------------------------------------------------------
// rast_checker: port-level checks of the refresh skip table
// Watches the handshakes and the sequencing seen at the top-level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rast_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_refresh,
    input wire logic [3:0] m_count_value
);

    // A word waiting on the result side stays there with its payload unchanged.
    `ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid)
    `ASSERT_NEXT(a_out_stable, m_valid && !m_ready, $stable(m_refresh) && $stable(m_count_value))

    // After an accept the block is busy with the table read and the write-back.
    `ASSERT_NEXT(a_busy_read, s_valid && s_ready, !s_ready)
    `ASSERT_NEXT2(a_busy_update, s_valid && s_ready, !s_ready)

endmodule

bind retention_aware_refresh_skip_table_top rast_checker u_rast_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_refresh     (m_refresh),
    .m_count_value (m_count_value)
);

`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench of the retention-aware refresh skip table
// Programs rows, runs refresh slot checks and count resets against an in-bench
// copy of both row tables, with random sender bursts, receiver stalls and
// several register settings. Every result word is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import rast_pkg::*;

    localparam int TABLE_DEPTH = 16 * 8 * 256;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_WORDS = 220;
    localparam int POOL_ROWS   = 8;
    localparam int PHASES      = 6;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic       refresh;
        logic [3:0] count;
    } skip_result_t;

    class refresh_scoreboard;
        logic [3:0]   reload_tbl [TABLE_DEPTH];
        logic [3:0]   count_tbl [TABLE_DEPTH];
        logic [4:0]   min_exp;
        logic [3:0]   max_skip;
        skip_result_t pending [$];
        int           errors;

        function new();
            min_exp  = MIN_EXP_RST;
            max_skip = MAX_SKIP_RST;
            errors   = 0;
        endfunction

        function void write_register(logic idx, logic [4:0] data);
            if (idx == CFG_MIN_EXP) begin
                min_exp = data;
            end else begin
                max_skip = data[3:0];
            end
        endfunction

        // Slots a row may skip: 2^(p - min_exp) - 1, capped at max_skip.
        function logic [3:0] skip_span(logic present, logic [4:0] p);
            int unsigned exp_gap;
            logic [3:0]  span;
            if (!present || p <= min_exp) begin
                return 4'd0;
            end
            exp_gap = p - min_exp;
            span = (exp_gap >= 4) ? 4'hF : 4'((1 << exp_gap) - 1);
            return (span > max_skip) ? max_skip : span;
        endfunction

        function void note_word(logic [1:0] mode, logic [3:0] v, logic [2:0] b,
                                logic [7:0] r, logic present, logic [4:0] p);
            logic [14:0]  idx;
            skip_result_t res;
            idx = {v, b, r};
            res = '0;
            case (mode)
                MODE_PROGRAM: begin
                    reload_tbl[idx] = skip_span(present, p);
                    count_tbl[idx]  = reload_tbl[idx];
                end
                MODE_REFRESH: begin
                    if (count_tbl[idx] == 4'd0) begin
                        res.refresh    = 1'b1;
                        count_tbl[idx] = reload_tbl[idx];
                    end else begin
                        count_tbl[idx] = count_tbl[idx] - 4'd1;
                    end
                    res.count = count_tbl[idx];
                end
                MODE_RESET: begin
                    count_tbl[idx] = reload_tbl[idx];
                    res.count      = count_tbl[idx];
                end
                default: ;
            endcase
            pending.push_back(res);
        endfunction

        function void check_word(logic refresh, logic [3:0] count);
            skip_result_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result word: refresh %0b count %0d",
                         $time, refresh, count);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (refresh !== want.refresh) begin
                $display("%0t: refresh mismatch: expected %0b, actual %0b",
                         $time, want.refresh, refresh);
                errors++;
            end
            if (count !== want.count) begin
                $display("%0t: count_value mismatch: expected %0d, actual %0d",
                         $time, want.count, count);
                errors++;
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_index;
    logic [4:0] cfg_data;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_mode;
    logic [3:0] s_vault_index;
    logic [2:0] s_bank_index;
    logic [7:0] s_row_index;
    logic       s_retention_present;
    logic [4:0] s_retention_log2;
    logic       m_valid;
    logic       m_ready;
    logic       m_refresh;
    logic [3:0] m_count_value;

    refresh_scoreboard sb;
    bit                programmed [TABLE_DEPTH];
    int                burst_left;
    bit                traffic_on;
    int unsigned       cycle_count;

    retention_aware_refresh_skip_table_top dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_mode              (s_mode),
        .s_vault_index       (s_vault_index),
        .s_bank_index        (s_bank_index),
        .s_row_index         (s_row_index),
        .s_retention_present (s_retention_present),
        .s_retention_log2    (s_retention_log2),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_refresh           (m_refresh),
        .m_count_value       (m_count_value)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_word(s_mode, s_vault_index, s_bank_index, s_row_index,
                             s_retention_present, s_retention_log2);
            end
            if (m_valid && m_ready) begin
                sb.check_word(m_refresh, m_count_value);
            end
            if (cfg_valid && cfg_ready) begin
                sb.write_register(cfg_index, cfg_data);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: segments of steady, random and periodic readiness, plus two
    // long hold-offs that back the table up into its input.
    initial begin
        int          seg_left;
        int          seg_kind;
        int          hold_left;
        int unsigned rx_cycles;
        seg_left  = 0;
        seg_kind  = 0;
        hold_left = 0;
        rx_cycles = 0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (traffic_on) begin
                rx_cycles++;
                if (rx_cycles == 150 || rx_cycles == 2000) begin
                    hold_left = 90;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_kind = $urandom_range(0, 3);
                    seg_left = $urandom_range(10, 60);
                end
                seg_left--;
                case (seg_kind)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= (rx_cycles % 3 != 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Called just after a rising edge; returns at the edge that takes the word.
    task automatic send_word(input logic [1:0] md, input logic [3:0] v,
                             input logic [2:0] b, input logic [7:0] r,
                             input logic pres, input logic [4:0] p);
        s_valid             <= 1'b1;
        s_mode              <= md;
        s_vault_index       <= v;
        s_bank_index        <= b;
        s_row_index         <= r;
        s_retention_present <= pres;
        s_retention_log2    <= p;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
    endtask

    // The first edge lets the monitor note a word taken at the calling edge.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_register(input logic idx, input logic [4:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_limits(input logic [4:0] exp_floor, input logic [3:0] skip_cap);
        write_register(CFG_MIN_EXP, exp_floor);
        write_register(CFG_MAX_SKIP, {1'b0, skip_cap});
        cfg_valid <= 1'b0;
    endtask

    // Mostly refresh slots on a small pool of rows so that counts run down to
    // zero and reload, with programs, count resets and the unused mode mixed in.
    task automatic issue_row_traffic(input int words, input logic [4:0] exp_floor);
        logic [14:0] pool [POOL_ROWS];
        logic [14:0] addr;
        int unsigned roll;
        logic [1:0]  md;
        logic        pres;
        logic [4:0]  p;
        int          t;
        for (int i = 0; i < POOL_ROWS; i++) begin
            pool[i] = 15'($urandom_range(0, TABLE_DEPTH - 1));
        end
        pool[0] = '0;
        pool[1] = '1;
        for (int n = 0; n < words; n++) begin
            roll = $urandom_range(0, 99);
            addr = pool[$urandom_range(0, POOL_ROWS - 1)];
            if (roll < 4) begin
                addr = 15'($urandom_range(0, TABLE_DEPTH - 1));
            end
            if (roll < 10 || !programmed[addr]) begin
                md = MODE_PROGRAM;
            end else if (roll < 93) begin
                md = MODE_REFRESH;
            end else if (roll < 97) begin
                md = MODE_RESET;
            end else begin
                md = MODE_UNUSED;
            end
            pres = ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 1) == 0) begin
                p = 5'($urandom_range(0, 31));
            end else begin
                t = int'(exp_floor) + int'($urandom_range(0, 6)) - 1;
                p = (t < 0) ? 5'd0 : (t > 31) ? 5'd31 : 5'(t);
            end
            if (md == MODE_PROGRAM) begin
                programmed[addr] = 1'b1;
            end
            pace_sender();
            send_word(md, addr[14:11], addr[10:8], addr[7:0], pres, p);
        end
    endtask

    initial begin
        logic [4:0] exp_set [PHASES];
        logic [3:0] skip_set [PHASES];
        sb                  = new();
        aresetn             = 1'b0;
        cfg_valid           = 1'b0;
        cfg_index           = 1'b0;
        cfg_data            = '0;
        s_valid             = 1'b0;
        s_mode              = MODE_PROGRAM;
        s_vault_index       = '0;
        s_bank_index        = '0;
        s_row_index         = '0;
        s_retention_present = 1'b0;
        s_retention_log2    = '0;
        burst_left          = 0;
        traffic_on          = 1'b0;
        exp_set  = '{5'd0, 5'd31, 5'd0, 5'd3, 5'd31, 5'($urandom_range(0, 31))};
        skip_set = '{4'd0, 4'd15, 4'd15, 4'd4, 4'd0, 4'($urandom_range(0, 15))};

        repeat (8) @(posedge aclk);
        aresetn    <= 1'b1;
        traffic_on <= 1'b1;

        // Directed part under the reset limits (min_exp 5, max_skip 9).
        programmed[{4'd0, 3'd0, 8'd0}]     = 1'b1;
        programmed[{4'd15, 3'd7, 8'd255}]  = 1'b1;
        programmed[{4'd5, 3'd2, 8'd170}]   = 1'b1;
        programmed[{4'd10, 3'd5, 8'd85}]   = 1'b1;
        send_word(MODE_PROGRAM, 4'd0, 3'd0, 8'd0, 1'b1, 5'd31);      // capped at max_skip
        send_word(MODE_PROGRAM, 4'd15, 3'd7, 8'd255, 1'b1, 5'd6);    // one slot skipped
        send_word(MODE_PROGRAM, 4'd5, 3'd2, 8'd170, 1'b0, 5'd31);    // no retention
        send_word(MODE_PROGRAM, 4'd10, 3'd5, 8'd85, 1'b1, 5'd5);     // exponent at min_exp
        send_word(MODE_REFRESH, 4'd15, 3'd7, 8'd255, 1'b0, 5'd0);
        send_word(MODE_REFRESH, 4'd15, 3'd7, 8'd255, 1'b1, 5'd31);
        send_word(MODE_REFRESH, 4'd5, 3'd2, 8'd170, 1'b0, 5'd0);
        send_word(MODE_REFRESH, 4'd0, 3'd0, 8'd0, 1'b0, 5'd0);
        send_word(MODE_REFRESH, 4'd0, 3'd0, 8'd0, 1'b0, 5'd0);
        send_word(MODE_RESET, 4'd0, 3'd0, 8'd0, 1'b0, 5'd0);
        send_word(MODE_UNUSED, 4'd0, 3'd0, 8'd0, 1'b1, 5'd31);
        send_word(MODE_REFRESH, 4'd0, 3'd0, 8'd0, 1'b0, 5'd0);
        send_word(MODE_REFRESH, 4'd10, 3'd5, 8'd85, 1'b0, 5'd0);
        send_word(MODE_PROGRAM, 4'd10, 3'd5, 8'd85, 1'b1, 5'd7);
        send_word(MODE_REFRESH, 4'd10, 3'd5, 8'd85, 1'b0, 5'd0);
        send_word(MODE_PROGRAM, 4'd5, 3'd2, 8'd170, 1'b1, 5'd0);
        send_word(MODE_PROGRAM, 4'd5, 3'd2, 8'd170, 1'b1, 5'd8);
        send_word(MODE_REFRESH, 4'd5, 3'd2, 8'd170, 1'b0, 5'd0);
        send_word(MODE_RESET, 4'd5, 3'd2, 8'd170, 1'b0, 5'd0);
        send_word(MODE_PROGRAM, 4'd15, 3'd7, 8'd255, 1'b1, 5'd9);    // wide span, capped

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            set_limits(exp_set[ph], skip_set[ph]);
            issue_row_traffic(PHASE_WORDS, exp_set[ph]);
        end

        wait_drained();
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
